// File: src/integer_square_root_62bit_core_assert.svh
// Assertion macros shared by the square root core.
`ifndef INTEGER_SQUARE_ROOT_62BIT_CORE_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_62BIT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define ISR62_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ISR62_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ISR62_ASSERT_NOW(label, cond, msg)
`define ISR62_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

// File: src/isr62_pkg.sv
// Types and constants of the 62-bit integer square root core.
package isr62_pkg;

  localparam int unsigned STEPS     = 32;
  localparam int unsigned REM_W     = 62;
  localparam int unsigned ACC_W     = 63;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned RAD_W     = 64;

  localparam logic [ROOT_W-1:0] ROOT_ALL_ONES = 32'hFFFF_FFFF;

  // Control that travels down the pipe with each request.
  typedef struct packed {
    logic valid;
    logic oor;    // radicand at or above 2^62
  } stage_ctrl_t;

endpackage

// File: src/isr62_stage.sv
// One restoring square root step with its pipeline register.
module isr62_stage
  import isr62_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  stage_ctrl_t       ctrl_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ACC_W-1:0]  acc_in,
  output stage_ctrl_t       ctrl,
  output logic [REM_W-1:0]  rem,
  output logic [ACC_W-1:0]  acc
);

  // Trial bit of this step: 2^(62 - 2*STEP).
  localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (STEPS - 1 - STEP));

  logic [ACC_W-1:0] trial;
  logic             fits;
  logic [REM_W-1:0] rem_next;
  logic [ACC_W-1:0] acc_next;

  always_comb begin
    trial = acc_in + BIT;
    fits  = {1'b0, rem_in} >= trial;
    if (fits) begin
      rem_next = rem_in - trial[REM_W-1:0];
      acc_next = (acc_in >> 1) + BIT;
    end else begin
      rem_next = rem_in;
      acc_next = acc_in >> 1;
    end
  end

  // Clear only the valid bit on reset; advance the payload whenever the pipe moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (advance) begin
      ctrl.valid <= ctrl_in.valid;
    end
    if (advance) begin
      ctrl.oor <= ctrl_in.oor;
      rem      <= rem_next;
      acc      <= acc_next;
    end
  end

endmodule

// File: src/integer_square_root_62bit_core.sv
// Top level of the pipelined 62-bit integer square root core.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+---------------------
//   request   | radicand_valid, radicand_stall | radicand [63:0]
//   result    | root_valid, root_stall         | root [31:0]
//
// There is one register stage per result bit, each doing one 63-bit add
// and compare plus a subtract. A request enters every cycle the pipe moves.
// The whole pipe advances together; a stalled result holds every stage and
// the request side sees the stall in the same cycle, so nothing drops.
// Empty slots move along, so a stall while the output is empty costs nothing.
// Reset clears only the valid bits; payload registers carry no reset.
module integer_square_root_62bit_core
  import isr62_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              radicand_valid,
  output logic              radicand_stall,
  input  logic [RAD_W-1:0]  radicand,
  output logic              root_valid,
  input  logic              root_stall,
  output logic [ROOT_W-1:0] root
);

`include "integer_square_root_62bit_core_assert.svh"

  stage_ctrl_t      ctrl_pipe [STEPS+1];
  logic [REM_W-1:0] rem_pipe  [STEPS+1];
  logic [ACC_W-1:0] acc_pipe  [STEPS+1];
  logic             advance;

  // Hold the pipe only when a finished result is waiting on the consumer.
  assign advance        = !(ctrl_pipe[STEPS].valid && root_stall);
  assign radicand_stall = !advance;

  // Feed the first step; a radicand with either top bit set is flagged.
  assign ctrl_pipe[0].valid = radicand_valid;
  assign ctrl_pipe[0].oor   = |radicand[RAD_W-1:REM_W];
  assign rem_pipe[0]        = radicand[REM_W-1:0];
  assign acc_pipe[0]        = '0;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    isr62_stage #(
      .STEP(s)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctrl_in (ctrl_pipe[s]),
      .rem_in  (rem_pipe[s]),
      .acc_in  (acc_pipe[s]),
      .ctrl    (ctrl_pipe[s+1]),
      .rem     (rem_pipe[s+1]),
      .acc     (acc_pipe[s+1])
    );
  end

  // After the last step the accumulator holds the root itself.
  assign root_valid = ctrl_pipe[STEPS].valid;
  assign root       = ctrl_pipe[STEPS].oor ? ROOT_ALL_ONES
                                           : acc_pipe[STEPS][ROOT_W-1:0];

  // An in-range root never reaches 2^31.
  `ISR62_ASSERT_IMPL(a_root_range, root_valid && !ctrl_pipe[STEPS].oor,
                     !root[ROOT_W-1], "in-range root has top bit set")

  // The final remainder of a valid in-range result is at most twice the root.
  `ISR62_ASSERT_IMPL(a_rem_bound, root_valid && !ctrl_pipe[STEPS].oor,
                     {1'b0, rem_pipe[STEPS]} <= {acc_pipe[STEPS][ACC_W-2:0], 1'b0},
                     "remainder exceeds bound")

  // The first stage takes in exactly the requests that were accepted.
  `ISR62_ASSERT_IMPL(a_entry, !$past(rst) && $past(advance),
                     ctrl_pipe[1].valid == $past(radicand_valid),
                     "first stage valid does not match accepted request")

  // The accumulator of a finished result fits in the root width.
  `ISR62_ASSERT_NOW(a_acc_fits,
                    !root_valid || acc_pipe[STEPS][ACC_W-1:ROOT_W] == '0,
                    "final accumulator wider than root")

endmodule
